// ----- sv/u16d_pkg.sv -----
// shared types and constants for the utf-16 byte stream decoder
// no dependencies
`default_nettype none

package u16d_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int CHAR_COUNT_W    = 24;
  localparam int UNIT_W          = 16;
  localparam int MAX_RES         = 3;
  localparam int RES_N_W         = 2;
  localparam int FIFO_DEPTH      = 4;

  localparam logic [UNIT_W-1:0] UNIT_BOM = 16'hFEFF;
  localparam logic [UNIT_W-1:0] UNIT_CR  = 16'h000D;
  localparam logic [UNIT_W-1:0] UNIT_LF  = 16'h000A;

  typedef enum logic [1:0] {
    REG_LOW_BYTE_FIRST = 2'd0,
    REG_FOLD_CR        = 2'd1,
    REG_DROP_BOM       = 2'd2
  } reg_index_t;

  typedef enum logic {
    KIND_CHAR    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef struct packed {
    logic low_byte_first;
    logic fold_cr;
    logic drop_bom;
  } cfg_t;

  typedef struct packed {
    logic [UNIT_W-1:0]       code_unit;
    kind_t                   kind;
    logic [CHAR_COUNT_W-1:0] char_count;
    logic                    all_ascii;
    logic                    last;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/utf16_byte_stream_decoder.sv -----
// top level of the utf-16 byte stream decoder
// holds the config registers; uses u16d_pkg, u16d_decode, u16d_fifo
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | data_byte, end_of_data
//  out     | output    | out_valid / out_stall| code_unit, kind, char_count, all_ascii, last
//  cfg     | input     | cfg_wr               | cfg_addr, cfg_data
//
// one byte is taken per cycle while in_stall is low; its zero to three results land in a 4-entry queue
// one result leaves the queue per cycle while out_stall is low, so the output port sets the pace
// in_stall rises while the queue holds two or more results
// synchronous reset clears stream state and queue; config resets to le, no crlf, drop bom
`default_nettype none

module utf16_byte_stream_decoder import u16d_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [7:0]              data_byte,
  input  wire logic                    end_of_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [UNIT_W-1:0]            code_unit,
  output logic                         kind,
  output logic [CHAR_COUNT_W-1:0]      char_count,
  output logic                         all_ascii,
  output logic                         last,
  input  wire logic                    cfg_wr,
  input  wire logic [1:0]              cfg_addr,
  input  wire logic                    cfg_data
);

  cfg_t                  cfg;
  logic                  accept;
  logic                  room;
  result_t [MAX_RES-1:0] res;
  logic [RES_N_W-1:0]    res_n;
  result_t               head_res;

  assign in_stall = !room;
  assign accept   = in_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_byte_first <= 1'b1;
      cfg.fold_cr        <= 1'b0;
      cfg.drop_bom       <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_addr)
        REG_LOW_BYTE_FIRST: cfg.low_byte_first <= cfg_data;
        REG_FOLD_CR:        cfg.fold_cr        <= cfg_data;
        REG_DROP_BOM:       cfg.drop_bom       <= cfg_data;
        default: ;
      endcase
    end
  end

  u16d_decode #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .end_of_data (end_of_data),
    .cfg         (cfg),
    .res         (res),
    .res_n       (res_n)
  );

  u16d_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_data (res),
    .push_n    (res_n),
    .room      (room),
    .pop_valid (out_valid),
    .pop_stall (out_stall),
    .pop_data  (head_res)
  );

  assign code_unit  = head_res.code_unit;
  assign kind       = head_res.kind;
  assign char_count = head_res.char_count;
  assign all_ascii  = head_res.all_ascii;
  assign last       = head_res.last;

  a_eod_gives_summary: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_data |-> res_n != '0)
    else $error("end of data produced no summary");

  a_summary_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_SUMMARY |-> last)
    else $error("summary result not marked last");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> !accept)
    else $error("byte taken while queue lacks room");

endmodule

`default_nettype wire

// ----- sv/u16d_decode.sv -----
// pairing, line-end and byte-order-mark logic plus per-stream state
// builds up to three results for each accepted byte; uses u16d_pkg
`default_nettype none

module u16d_decode import u16d_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        end_of_data,
  input  wire cfg_t                        cfg,
  output result_t [MAX_RES-1:0]            res,
  output logic    [RES_N_W-1:0]            res_n
);

  logic [7:0]             held_byte, held_byte_next;
  logic                   have_held, have_held_next;
  logic                   pending_cr, pending_cr_next;
  logic                   ascii_so_far, ascii_so_far_next;
  logic [COUNT_WIDTH-1:0] emitted_count, emitted_count_next;
  logic                   first_unit_seen, first_unit_seen_next;

  logic [UNIT_W-1:0]      unit;
  logic                   keep, emit_lf1, emit_unit, emit_lf2, pcr_after;
  logic [UNIT_W-1:0]      code2;
  logic                   v2;
  logic [COUNT_WIDTH-1:0] cnt1, cnt2;
  logic                   asc2;
  result_t                e0, e1, e2;
  logic [CHAR_COUNT_W-1:0] rep1, rep2;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    sat_inc = (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic [CHAR_COUNT_W-1:0] report(input logic [COUNT_WIDTH-1:0] c);
    logic [CHAR_COUNT_W-1:0] r;
    if (COUNT_WIDTH > CHAR_COUNT_W) begin
      r = (c > COUNT_WIDTH'({CHAR_COUNT_W{1'b1}})) ? {CHAR_COUNT_W{1'b1}}
                                                  : CHAR_COUNT_W'(c);
    end else begin
      r = CHAR_COUNT_W'(c);
    end
    return r;
  endfunction

  always_comb begin
    unit = cfg.low_byte_first ? {data_byte, held_byte} : {held_byte, data_byte};
    keep = have_held && !(!first_unit_seen && cfg.drop_bom && unit == UNIT_BOM);
    emit_lf1  = keep && pending_cr && unit != UNIT_LF;
    emit_unit = keep && !(cfg.fold_cr && unit == UNIT_CR);
    pcr_after = keep ? (cfg.fold_cr && unit == UNIT_CR) : pending_cr;
    // a cr left pending at end of stream still yields its lf
    emit_lf2  = end_of_data && pcr_after;
    // unit and trailing lf never occur together
    v2    = emit_unit || emit_lf2;
    code2 = emit_unit ? unit : UNIT_LF;

    cnt1 = emit_lf1 ? sat_inc(emitted_count) : emitted_count;
    cnt2 = v2 ? sat_inc(cnt1) : cnt1;
    asc2 = ascii_so_far && !(v2 && code2[UNIT_W-1:7] != '0);
    rep1 = report(cnt1);
    rep2 = report(cnt2);

    e0.code_unit  = UNIT_LF;
    e0.kind       = KIND_CHAR;
    e0.char_count = rep1;
    e0.all_ascii  = ascii_so_far;
    e0.last       = !v2 && !end_of_data;

    e1.code_unit  = code2;
    e1.kind       = KIND_CHAR;
    e1.char_count = rep2;
    e1.all_ascii  = asc2;
    e1.last       = !end_of_data;

    e2.code_unit  = '0;
    e2.kind       = KIND_SUMMARY;
    e2.char_count = rep2;
    e2.all_ascii  = asc2;
    e2.last       = 1'b1;

    // pack the valid entries to the front, order kept
    res[0] = emit_lf1 ? e0 : (v2 ? e1 : e2);
    res[1] = emit_lf1 ? (v2 ? e1 : e2) : e2;
    res[2] = e2;
    res_n  = accept ? RES_N_W'({1'b0, emit_lf1} + {1'b0, v2} + {1'b0, end_of_data})
                    : '0;
  end

  always_comb begin
    held_byte_next       = held_byte;
    have_held_next       = have_held;
    pending_cr_next      = pending_cr;
    ascii_so_far_next    = ascii_so_far;
    emitted_count_next   = emitted_count;
    first_unit_seen_next = first_unit_seen;
    if (accept) begin
      if (end_of_data) begin
        held_byte_next       = '0;
        have_held_next       = 1'b0;
        pending_cr_next      = 1'b0;
        ascii_so_far_next    = 1'b1;
        emitted_count_next   = '0;
        first_unit_seen_next = 1'b0;
      end else if (!have_held) begin
        held_byte_next = data_byte;
        have_held_next = 1'b1;
      end else begin
        held_byte_next       = '0;
        have_held_next       = 1'b0;
        first_unit_seen_next = 1'b1;
        pending_cr_next      = pcr_after;
        ascii_so_far_next    = asc2;
        emitted_count_next   = cnt2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte       <= '0;
      have_held       <= 1'b0;
      pending_cr      <= 1'b0;
      ascii_so_far    <= 1'b1;
      emitted_count   <= '0;
      first_unit_seen <= 1'b0;
    end else begin
      held_byte       <= held_byte_next;
      have_held       <= have_held_next;
      pending_cr      <= pending_cr_next;
      ascii_so_far    <= ascii_so_far_next;
      emitted_count   <= emitted_count_next;
      first_unit_seen <= first_unit_seen_next;
    end
  end

  a_eod_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_data |=> !have_held && !pending_cr && emitted_count == '0
                              && ascii_so_far && !first_unit_seen)
    else $error("stream state not cleared after end of data");

  a_first_byte_held: assert property (@(posedge clk) disable iff (rst)
    accept && !end_of_data && !have_held |=> have_held && held_byte == $past(data_byte))
    else $error("first byte of a pair not held");

  a_pending_needs_pairing: assert property (@(posedge clk) disable iff (rst)
    $rose(pending_cr) |-> $past(accept) && $past(have_held) && $past(cfg.fold_cr))
    else $error("pending cr set without a completed cr unit");

endmodule

`default_nettype wire

// ----- sv/u16d_fifo.sv -----
// result queue: takes up to three results a cycle, hands out one while pop_stall is low
// uses u16d_pkg for the result type and depth
`default_nettype none

module u16d_fifo import u16d_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire result_t [MAX_RES-1:0] push_data,
  input  wire logic [RES_N_W-1:0]   push_n,
  output logic                      room,
  output logic                      pop_valid,
  input  wire logic                 pop_stall,
  output result_t                   pop_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t [FIFO_DEPTH-1:0] entry;
  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [PTR_W-1:0] tail;
  logic             pop;

  assign pop_valid = count != '0;
  assign pop_data  = entry[head];
  assign pop       = pop_valid && !pop_stall;
  // room for a worst-case burst of results
  assign room      = count <= CNT_W'(FIFO_DEPTH - MAX_RES);
  assign tail      = head + PTR_W'(count);

  always_comb begin
    head_next  = pop ? head + 1'b1 : head;
    count_next = count + CNT_W'(push_n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (RES_N_W'(i) < push_n) begin
        entry[tail + PTR_W'(i)] <= push_data[i];
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push_n != '0 |-> room)
    else $error("results pushed without room");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    pop && push_n == '0 |=> count == $past(count) - 1'b1)
    else $error("queue count did not follow a lone pop");

endmodule

`default_nettype wire
